// ===== design/rcft_pkg.sv =====
// ----------------------------------------------------------------------------
// rcft_pkg
// Shared widths, cipher constants, register indexes and types of the
// rolling-code frame transmitter.
// ----------------------------------------------------------------------------
package rcft_pkg;

    localparam int unsigned SERIAL_W    = 28;
    localparam int unsigned KEY_W       = 64;
    localparam int unsigned DISC_W      = 12;
    localparam int unsigned BUTTON_W    = 4;
    localparam int unsigned REPEAT_W    = 7;
    localparam int unsigned HOP_W       = 32;
    localparam int unsigned COUNTER_W   = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam int unsigned MAX_REPEAT_DEFAULT = 64;

    localparam logic [HOP_W-1:0] KLQ_NLF    = 32'h3A5C_742E;
    localparam int unsigned      KLQ_ROUNDS = 528;
    localparam int unsigned      ROUND_W    = $clog2(KLQ_ROUNDS);
    localparam int unsigned      KEY_IDX_W  = $clog2(KEY_W);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEVICE_SERIAL = 2'd0,
        REG_CIPHER_KEY    = 2'd1,
        REG_DISC_VALUE    = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } tx_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cipher_stat_t;

endpackage

// ===== design/rcft_cipher.sv =====
// ----------------------------------------------------------------------------
// rcft_cipher
// KeeLoq encryption core: one nonlinear feedback round per cycle over the
// full 528 rounds, result held until the next start.
// ----------------------------------------------------------------------------
module rcft_cipher (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start_i,
    input  logic [rcft_pkg::HOP_W-1:0]      plain_i,
    input  logic [rcft_pkg::KEY_W-1:0]      key_i,
    output rcft_pkg::cipher_stat_t          stat_o,
    output logic [rcft_pkg::HOP_W-1:0]      data_o
);

    logic [rcft_pkg::HOP_W-1:0]   data_reg;
    logic [rcft_pkg::ROUND_W-1:0] round_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [4:0] nlf_idx;
    logic       key_bit;
    logic       feedback;

    always_comb begin
        nlf_idx  = {data_reg[31], data_reg[26], data_reg[20], data_reg[9], data_reg[1]};
        key_bit  = key_i[round_reg[rcft_pkg::KEY_IDX_W-1:0]];
        feedback = data_reg[0] ^ data_reg[16] ^ key_bit ^ rcft_pkg::KLQ_NLF[nlf_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else if (start_i) begin
            data_reg  <= plain_i;
            round_reg <= '0;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end else if (busy_reg) begin
            data_reg  <= {feedback, data_reg[rcft_pkg::HOP_W-1:1]};
            round_reg <= round_reg + 1'b1;
            if (round_reg == rcft_pkg::ROUND_W'(rcft_pkg::KLQ_ROUNDS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign stat_o.busy = busy_reg;
    assign stat_o.done = done_reg;
    assign data_o      = data_reg;

endmodule

// ===== design/rolling_code_frame_transmitter_unit.sv =====
// ----------------------------------------------------------------------------
// rolling_code_frame_transmitter_unit
// Rolling-code transmitter: sends each button request as a run of KeeLoq
// encrypted frames and advances the synchronisation counter per frame.
// ----------------------------------------------------------------------------
// Each accepted word asks for min(repeat_count, MAX_REPEAT) frames; a request
// for zero frames is dropped and leaves the counter alone. The cipher core
// encrypts each frame in its 528 rounds at one round per cycle; s_ready stays
// low while a word's frames are sent. A finished frame sits in the output
// register while the next frame is already encrypting. The counter wraps from
// 65535 to 0. Registers are to be written only while idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module rolling_code_frame_transmitter_unit #(
    parameter int unsigned MAX_REPEAT = rcft_pkg::MAX_REPEAT_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rcft_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rcft_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rcft_pkg::BUTTON_W-1:0]       s_button_code,
    input  logic [rcft_pkg::REPEAT_W-1:0]       s_repeat_count,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rcft_pkg::HOP_W-1:0]          m_hop_code,
    output logic [rcft_pkg::SERIAL_W-1:0]       m_serial_out,
    output logic [rcft_pkg::BUTTON_W-1:0]       m_button_out,
    output logic [rcft_pkg::COUNTER_W-1:0]      m_counter_used,
    output logic                                m_last_frame
);

    localparam int unsigned RPT_W = $clog2(MAX_REPEAT + 1);
    localparam int unsigned CMP_W = (RPT_W > rcft_pkg::REPEAT_W) ? RPT_W : rcft_pkg::REPEAT_W;

    rcft_pkg::tx_state_t state_reg, state_next;

    logic [rcft_pkg::SERIAL_W-1:0]  device_serial_reg;
    logic [rcft_pkg::KEY_W-1:0]     cipher_key_reg;
    logic [rcft_pkg::DISC_W-1:0]    disc_value_reg;
    logic [rcft_pkg::COUNTER_W-1:0] sync_counter_reg, sync_counter_next;
    logic [RPT_W-1:0]               remaining_reg, remaining_next;
    logic [rcft_pkg::BUTTON_W-1:0]  button_reg, button_next;
    logic                           m_valid_reg, m_valid_next;

    logic [rcft_pkg::HOP_W-1:0]     hop_reg;
    logic [rcft_pkg::SERIAL_W-1:0]  serial_reg;
    logic [rcft_pkg::BUTTON_W-1:0]  button_out_reg;
    logic [rcft_pkg::COUNTER_W-1:0] counter_used_reg;
    logic                           last_frame_reg;

    logic [CMP_W-1:0]               req_ext;
    logic [CMP_W-1:0]               max_ext;
    logic [RPT_W-1:0]               frames_sat;
    logic                           out_free;
    logic                           load;
    logic                           cipher_start;
    logic [rcft_pkg::BUTTON_W-1:0]  plain_button;
    logic [rcft_pkg::COUNTER_W-1:0] plain_counter;
    logic [rcft_pkg::HOP_W-1:0]     plain;

    rcft_pkg::cipher_stat_t         cipher_stat;
    logic [rcft_pkg::HOP_W-1:0]     cipher_data;

    rcft_cipher u_cipher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (cipher_start),
        .plain_i (plain),
        .key_i   (cipher_key_reg),
        .stat_o  (cipher_stat),
        .data_o  (cipher_data)
    );

    always_comb begin
        req_ext    = CMP_W'(s_repeat_count);
        max_ext    = CMP_W'(MAX_REPEAT);
        frames_sat = (req_ext > max_ext) ? RPT_W'(max_ext) : RPT_W'(req_ext);
    end

    always_comb begin
        state_next        = state_reg;
        remaining_next    = remaining_reg;
        button_next       = button_reg;
        sync_counter_next = sync_counter_reg;
        s_ready           = 1'b0;
        load              = 1'b0;
        cipher_start      = 1'b0;
        out_free          = !m_valid_reg || m_ready;
        plain_button      = button_reg;
        plain_counter     = sync_counter_reg + 1'b1;

        case (state_reg)
            rcft_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                plain_button  = s_button_code;
                plain_counter = sync_counter_reg;
                if (s_valid && (frames_sat != '0)) begin
                    cipher_start   = 1'b1;
                    remaining_next = frames_sat;
                    button_next    = s_button_code;
                    state_next     = rcft_pkg::ST_RUN;
                end
            end
            rcft_pkg::ST_RUN: begin
                if (cipher_stat.done && out_free) begin
                    load              = 1'b1;
                    sync_counter_next = sync_counter_reg + 1'b1;
                    remaining_next    = remaining_reg - 1'b1;
                    if (remaining_reg == RPT_W'(1)) begin
                        state_next = rcft_pkg::ST_IDLE;
                    end else begin
                        cipher_start = 1'b1;
                    end
                end
            end
            default: begin
                state_next = rcft_pkg::ST_IDLE;
            end
        endcase

        plain        = {plain_button, disc_value_reg, plain_counter};
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= rcft_pkg::ST_IDLE;
            sync_counter_reg  <= '0;
            remaining_reg     <= '0;
            m_valid_reg       <= 1'b0;
            device_serial_reg <= '0;
            cipher_key_reg    <= '0;
            disc_value_reg    <= '0;
        end else begin
            state_reg        <= state_next;
            sync_counter_reg <= sync_counter_next;
            remaining_reg    <= remaining_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_wr_en) begin
                if (cfg_index == rcft_pkg::REG_DEVICE_SERIAL) begin
                    device_serial_reg <= cfg_wdata[rcft_pkg::SERIAL_W-1:0];
                end
                if (cfg_index == rcft_pkg::REG_CIPHER_KEY) begin
                    cipher_key_reg <= cfg_wdata[rcft_pkg::KEY_W-1:0];
                end
                if (cfg_index == rcft_pkg::REG_DISC_VALUE) begin
                    disc_value_reg <= cfg_wdata[rcft_pkg::DISC_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        button_reg <= button_next;
        if (load) begin
            hop_reg          <= cipher_data;
            serial_reg       <= device_serial_reg;
            button_out_reg   <= button_reg;
            counter_used_reg <= sync_counter_reg;
            last_frame_reg   <= (remaining_reg == RPT_W'(1));
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hop_code      = hop_reg;
    assign m_serial_out    = serial_reg;
    assign m_button_out    = button_out_reg;
    assign m_counter_used  = counter_used_reg;
    assign m_last_frame    = last_frame_reg;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cipher_stat.busy |-> !s_ready)
        else $error("input ready while cipher busy");

    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> sync_counter_reg == rcft_pkg::COUNTER_W'($past(sync_counter_reg) + 1'b1))
        else $error("counter did not advance on frame load");

    a_run_has_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rcft_pkg::ST_RUN) |-> (remaining_reg != '0))
        else $error("running with no frames left");

    a_last_frame_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && (remaining_reg == RPT_W'(1))) |=>
            ((state_reg == rcft_pkg::ST_IDLE) && m_valid && m_last_frame))
        else $error("final frame not flagged or block not idle");

    a_load_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cipher_stat.done && !cipher_stat.busy))
        else $error("frame loaded before encryption finished");
`endif

endmodule

// ===== test/rcft_frame_checker.sv =====
// ----------------------------------------------------------------------------
// rcft_frame_checker
// Watches the register port and both channels of the rolling-code transmitter,
// keeps its own copy of the registers and the synchronisation counter,
// encrypts each predicted frame with a bit-serial KeeLoq model and compares
// every frame leaving the block, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rcft_frame_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [rcft_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcft_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [rcft_pkg::BUTTON_W-1:0]    s_button_code,
    input  logic [rcft_pkg::REPEAT_W-1:0]    s_repeat_count,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [rcft_pkg::HOP_W-1:0]       m_hop_code,
    input  logic [rcft_pkg::SERIAL_W-1:0]    m_serial_out,
    input  logic [rcft_pkg::BUTTON_W-1:0]    m_button_out,
    input  logic [rcft_pkg::COUNTER_W-1:0]   m_counter_used,
    input  logic                             m_last_frame,
    output int                               fail_count,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rcft_pkg::HOP_W-1:0]     hop;
        logic [rcft_pkg::SERIAL_W-1:0]  serial;
        logic [rcft_pkg::BUTTON_W-1:0]  button;
        logic [rcft_pkg::COUNTER_W-1:0] counter;
        logic                           last;
    } frame_t;

    logic [rcft_pkg::SERIAL_W-1:0]  serial_reg;
    logic [rcft_pkg::KEY_W-1:0]     key_reg;
    logic [rcft_pkg::DISC_W-1:0]    disc_reg;
    logic [rcft_pkg::COUNTER_W-1:0] next_counter;
    frame_t                         frames_due[$];
    int                             errors = 0;

    function automatic logic [rcft_pkg::HOP_W-1:0] encrypt_hop(
        input logic [rcft_pkg::HOP_W-1:0] plain,
        input logic [rcft_pkg::KEY_W-1:0] key);
        logic [rcft_pkg::HOP_W-1:0] x;
        logic [4:0]                 sel;
        logic                       fb;
        x = plain;
        for (int r = 0; r < rcft_pkg::KLQ_ROUNDS; r++) begin
            sel = {x[31], x[26], x[20], x[9], x[1]};
            fb  = x[0] ^ x[16] ^ key[r % rcft_pkg::KEY_W] ^ rcft_pkg::KLQ_NLF[sel];
            x   = {fb, x[rcft_pkg::HOP_W-1:1]};
        end
        return x;
    endfunction

    function automatic void queue_frames(input logic [rcft_pkg::BUTTON_W-1:0] btn,
                                         input logic [rcft_pkg::REPEAT_W-1:0] rep);
        int     n;
        frame_t f;
        n = (rep > rcft_pkg::MAX_REPEAT_DEFAULT) ? rcft_pkg::MAX_REPEAT_DEFAULT : int'(rep);
        for (int i = 0; i < n; i++) begin
            f.hop     = encrypt_hop({btn, disc_reg, next_counter}, key_reg);
            f.serial  = serial_reg;
            f.button  = btn;
            f.counter = next_counter;
            f.last    = (i == n - 1);
            frames_due.push_back(f);
            next_counter = next_counter + 1'b1;
        end
    endfunction

    function automatic void check_frame();
        frame_t want;
        if (frames_due.size() == 0) begin
            $error("unexpected frame: hop_code %h counter_used %0d",
                   m_hop_code, m_counter_used);
            errors++;
            return;
        end
        want = frames_due.pop_front();
        if (m_hop_code !== want.hop) begin
            $error("hop_code: expected %h, actual %h", want.hop, m_hop_code);
            errors++;
        end
        if (m_serial_out !== want.serial) begin
            $error("serial_out: expected %h, actual %h", want.serial, m_serial_out);
            errors++;
        end
        if (m_button_out !== want.button) begin
            $error("button_out: expected %h, actual %h", want.button, m_button_out);
            errors++;
        end
        if (m_counter_used !== want.counter) begin
            $error("counter_used: expected %0d, actual %0d", want.counter, m_counter_used);
            errors++;
        end
        if (m_last_frame !== want.last) begin
            $error("last_frame: expected %b, actual %b", want.last, m_last_frame);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            serial_reg   = '0;
            key_reg      = '0;
            disc_reg     = '0;
            next_counter = '0;
            frames_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_frame();
            end
            if (s_valid && s_ready) begin
                queue_frames(s_button_code, s_repeat_count);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    rcft_pkg::REG_DEVICE_SERIAL:
                        serial_reg = cfg_wdata[rcft_pkg::SERIAL_W-1:0];
                    rcft_pkg::REG_CIPHER_KEY:
                        key_reg    = cfg_wdata[rcft_pkg::KEY_W-1:0];
                    rcft_pkg::REG_DISC_VALUE:
                        disc_reg   = cfg_wdata[rcft_pkg::DISC_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count  <= errors;
        outstanding <= frames_due.size();
    end

endmodule

// ===== test/tb_rolling_code_frame_transmitter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rolling_code_frame_transmitter_unit
// Drives button requests and register writes into the rolling-code
// transmitter: a directed set of edge cases, then random phases under
// random register settings with bursty stalls on both channels, the last
// phase without stalls. The frame checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_rolling_code_frame_transmitter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rcft_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam int RANDOM_PHASES   = 4;
    localparam int WORDS_PER_PHASE = 87;
    localparam int SETTLE_CYCLES   = 16;
    localparam int TAIL_CYCLES     = 1100;

    logic                             aclk           = 1'b0;
    logic                             aresetn        = 1'b0;
    logic                             cfg_wr_en      = 1'b0;
    logic [rcft_pkg::CFG_INDEX_W-1:0] cfg_index      = rcft_pkg::REG_DEVICE_SERIAL;
    logic [rcft_pkg::CFG_DATA_W-1:0]  cfg_wdata      = '0;
    logic                             s_valid        = 1'b0;
    logic                             s_ready;
    logic [rcft_pkg::BUTTON_W-1:0]    s_button_code  = '0;
    logic [rcft_pkg::REPEAT_W-1:0]    s_repeat_count = '0;
    logic                             m_valid;
    logic                             m_ready        = 1'b0;
    logic [rcft_pkg::HOP_W-1:0]       m_hop_code;
    logic [rcft_pkg::SERIAL_W-1:0]    m_serial_out;
    logic [rcft_pkg::BUTTON_W-1:0]    m_button_out;
    logic [rcft_pkg::COUNTER_W-1:0]   m_counter_used;
    logic                             m_last_frame;
    int                               fail_count;
    int                               outstanding;
    bit                               idling = 1'b1;

    rolling_code_frame_transmitter_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_button_code   (s_button_code),
        .s_repeat_count  (s_repeat_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hop_code      (m_hop_code),
        .m_serial_out    (m_serial_out),
        .m_button_out    (m_button_out),
        .m_counter_used  (m_counter_used),
        .m_last_frame    (m_last_frame)
    );

    rcft_frame_checker u_frame_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_button_code   (s_button_code),
        .s_repeat_count  (s_repeat_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hop_code      (m_hop_code),
        .m_serial_out    (m_serial_out),
        .m_button_out    (m_button_out),
        .m_counter_used  (m_counter_used),
        .m_last_frame    (m_last_frame),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #500ms;
        $display("simulation failed");
        $finish;
    end

    // stall the frame output in random bursts
    initial begin
        forever begin
            if (idling && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_word(input logic [rcft_pkg::BUTTON_W-1:0] btn,
                             input logic [rcft_pkg::REPEAT_W-1:0] rep);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_button_code  <= btn;
        s_repeat_count <= rep;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold until every predicted frame has left the block
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [rcft_pkg::SERIAL_W-1:0] serial,
                              input logic [rcft_pkg::KEY_W-1:0]    key,
                              input logic [rcft_pkg::DISC_W-1:0]   disc);
        cfg_wr_en <= 1'b1;
        cfg_index <= rcft_pkg::REG_DEVICE_SERIAL;
        cfg_wdata <= {$urandom, 4'($urandom), serial};
        @(posedge aclk);
        cfg_index <= rcft_pkg::REG_CIPHER_KEY;
        cfg_wdata <= key;
        @(posedge aclk);
        cfg_index <= rcft_pkg::REG_DISC_VALUE;
        cfg_wdata <= {$urandom, 20'($urandom), disc};
        @(posedge aclk);
        cfg_index <= REG_UNMAPPED;
        cfg_wdata <= {$urandom, $urandom};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [rcft_pkg::SERIAL_W-1:0] serial;
        logic [rcft_pkg::KEY_W-1:0]    key;
        logic [rcft_pkg::DISC_W-1:0]   disc;
        logic [rcft_pkg::REPEAT_W-1:0] rep;
        int                            pick;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(4'h0, 7'd1);
        send_word(4'hF, 7'd1);
        drain();

        write_regs({rcft_pkg::SERIAL_W{1'b1}}, {rcft_pkg::KEY_W{1'b1}},
                   {rcft_pkg::DISC_W{1'b1}});
        send_word(4'hF, 7'd2);
        send_word(4'h0, 7'd0);
        send_word(4'hA, 7'd1);
        send_word(4'h5, 7'd1);
        send_word(4'h1, 7'd64);
        send_word(4'h2, 7'd65);
        send_word(4'h4, 7'd127);
        send_word(4'h9, 7'd0);
        send_word(4'h8, 7'd3);
        send_word(4'h3, 7'd1);
        send_word(4'hC, 7'd1);
        send_word(4'h6, 7'd1);
        send_word(4'h9, 7'd1);
        send_word(4'h7, 7'd1);
        send_word(4'hB, 7'd1);
        send_word(4'hD, 7'd1);
        send_word(4'hE, 7'd1);
        drain();

        write_regs('0, {$urandom, $urandom}, '0);
        send_word(4'h1, 7'd2);
        send_word(4'h2, 7'd1);
        send_word(4'h4, 7'd3);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            idling = (phase != RANDOM_PHASES - 1);
            pick   = $urandom_range(0, 3);
            serial = (pick == 0) ? {rcft_pkg::SERIAL_W{1'b0}} :
                     (pick == 1) ? {rcft_pkg::SERIAL_W{1'b1}} :
                                   rcft_pkg::SERIAL_W'($urandom);
            pick   = $urandom_range(0, 3);
            key    = (pick == 0) ? {rcft_pkg::KEY_W{1'b0}} :
                     (pick == 1) ? {rcft_pkg::KEY_W{1'b1}} : {$urandom, $urandom};
            pick   = $urandom_range(0, 3);
            disc   = (pick == 0) ? {rcft_pkg::DISC_W{1'b0}} :
                     (pick == 1) ? {rcft_pkg::DISC_W{1'b1}} : rcft_pkg::DISC_W'($urandom);
            write_regs(serial, key, disc);
            for (int w = 0; w < WORDS_PER_PHASE; w++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    rep = '0;
                end else if (pick < 93) begin
                    rep = rcft_pkg::REPEAT_W'($urandom_range(1, 2));
                end else if (pick < 99) begin
                    rep = rcft_pkg::REPEAT_W'($urandom_range(3, 8));
                end else begin
                    rep = rcft_pkg::REPEAT_W'($urandom_range(9, 127));
                end
                send_word(rcft_pkg::BUTTON_W'($urandom_range(0, 15)), rep);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
